>>> hdl/calendar_date_facts_defines.svh
// Assertion macros shared by the calendar_date_facts RTL.
`ifndef CALENDAR_DATE_FACTS_DEFINES_SVH
`define CALENDAR_DATE_FACTS_DEFINES_SVH

// Same-cycle implication, checked on clock, off during reset.
`define CDF_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on clock, off during reset.
`define CDF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/cdf_pkg.sv
`timescale 1ns / 1ps
package cdf_pkg;

   localparam int DayWidth   = 5;
   localparam int MonthWidth = 4;
   localparam int YearWidth  = 14;

   // x / 25 == (x * 5243) >> 17 for every x below 43690
   localparam logic [12:0] DIV25_MUL   = 13'd5243;
   localparam int          DIV25_SHIFT = 17;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   localparam logic [2:0] WD_FRIDAY   = 3'd5;
   localparam logic [2:0] WD_SATURDAY = 3'd6;

   typedef struct packed {
      logic [2:0] weekday;
      logic       is_week_end_day;
      logic       is_weekend;
      logic       is_business_day;
      logic [2:0] days_to_week_end;
      logic       is_leap;
      logic [4:0] month_length;
      logic [4:0] days_to_month_end;
      logic [8:0] days_to_year_end;
      logic       valid_res;
   } result_type;

   function automatic logic [4:0] month_days(input logic [3:0] m);
      logic [4:0] r;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
         4'd2:                                       r = 5'd28;
         default:                                    r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] r;
      case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // (31 * n) / 12 with March as n = 1, January and February as n = 11, 12
   function automatic logic [4:0] month_term(input logic [3:0] m);
      logic [4:0] r;
      case (m)
         4'd1:    r = 5'd28;
         4'd2:    r = 5'd31;
         4'd3:    r = 5'd2;
         4'd4:    r = 5'd5;
         4'd5:    r = 5'd7;
         4'd6:    r = 5'd10;
         4'd7:    r = 5'd12;
         4'd8:    r = 5'd15;
         4'd9:    r = 5'd18;
         4'd10:   r = 5'd20;
         4'd11:   r = 5'd23;
         4'd12:   r = 5'd25;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/cdf_leap.sv
`timescale 1ns / 1ps
module cdf_leap (
   input  logic [cdf_pkg::YearWidth-1:0] year,
   output logic                          is_leap
);
   import cdf_pkg::*;

   logic [11:0] y4;
   logic [24:0] prod;
   logic [7:0]  q;
   logic [11:0] rem;
   logic        div4;
   logic        div100;

   assign y4     = year[13:2];
   assign prod   = {13'd0, y4} * {12'd0, DIV25_MUL};
   assign q      = prod[DIV25_SHIFT +: 8];
   assign rem    = y4 - ({4'd0, q} * 12'd25);
   assign div4   = (year[1:0] == 2'd0);
   assign div100 = div4 && (rem == 12'd0);
   // divisible by 400 when year / 100 is a multiple of four
   assign is_leap = (div4 && !div100) || (div100 && (q[1:0] == 2'd0));

endmodule

>>> hdl/cdf_weekday.sv
`timescale 1ns / 1ps
module cdf_weekday (
   input  logic [cdf_pkg::DayWidth-1:0]   day,
   input  logic [cdf_pkg::MonthWidth-1:0] month,
   input  logic [cdf_pkg::YearWidth-1:0]  year,
   output logic [2:0]                     weekday
);
   import cdf_pkg::*;

   logic        early;
   logic [14:0] yy;
   logic [12:0] yy4;
   logic [25:0] prod;
   logic [7:0]  q100;
   logic [5:0]  q400;
   logic [14:0] sum;
   logic [5:0]  fold1;
   logic [3:0]  fold2;
   logic [2:0]  fold3;

   // January and February count as months of the previous year
   assign early = (month <= MONTH_FEB);
   assign yy    = {1'b0, year} + 15'd400 - {14'd0, early};
   assign yy4   = yy[14:2];
   assign prod  = {13'd0, yy4} * {13'd0, DIV25_MUL};
   assign q100  = prod[DIV25_SHIFT +: 8];
   assign q400  = q100[7:2];

   assign sum = {10'd0, day} + yy + {2'd0, yy4} - {7'd0, q100} + {9'd0, q400}
              + {10'd0, month_term(month)};

   // mod 7 by summing octal digits, since 8 == 1 mod 7
   assign fold1 = {3'd0, sum[2:0]} + {3'd0, sum[5:3]} + {3'd0, sum[8:6]}
                + {3'd0, sum[11:9]} + {3'd0, sum[14:12]};
   assign fold2 = {1'b0, fold1[2:0]} + {1'b0, fold1[5:3]};
   assign fold3 = fold2[2:0] + {2'd0, fold2[3]};
   assign weekday = (fold3 == 3'd7) ? 3'd0 : fold3;

endmodule

>>> hdl/cdf_calc.sv
`timescale 1ns / 1ps
module cdf_calc (
   input  logic [cdf_pkg::DayWidth-1:0]   day,
   input  logic [cdf_pkg::MonthWidth-1:0] month,
   input  logic [cdf_pkg::YearWidth-1:0]  year,
   output cdf_pkg::result_type            result
);
   import cdf_pkg::*;

   logic       leap;
   logic [2:0] wd;
   logic       mvalid;
   logic [4:0] mlen;
   logic       dvalid;
   logic [8:0] doy;
   logic [8:0] ylen;

   cdf_leap u_leap (
      .year    (year),
      .is_leap (leap)
   );

   cdf_weekday u_weekday (
      .day     (day),
      .month   (month),
      .year    (year),
      .weekday (wd)
   );

   assign mvalid = (month >= MONTH_JAN) && (month <= MONTH_DEC);
   assign mlen   = !mvalid ? 5'd0 :
                   (month == MONTH_FEB) ? (leap ? 5'd29 : 5'd28) : month_days(month);
   assign dvalid = mvalid && (day != 5'd0) && (day <= mlen);
   assign doy    = days_before(month) + {4'd0, day}
                 + {8'd0, (leap && (month > MONTH_FEB))};
   assign ylen   = leap ? 9'd366 : 9'd365;

   always_comb begin
      result                   = '0;
      result.is_leap           = leap;
      result.month_length      = mlen;
      result.valid_res         = dvalid;
      if (dvalid) begin
         result.weekday           = wd;
         result.is_week_end_day   = (wd == WD_SATURDAY);
         result.is_weekend        = (wd == WD_FRIDAY) || (wd == WD_SATURDAY);
         result.is_business_day   = !((wd == WD_FRIDAY) || (wd == WD_SATURDAY));
         result.days_to_week_end  = WD_SATURDAY - wd;
         result.days_to_month_end = mlen - day + 5'd1;
         result.days_to_year_end  = ylen - doy + 9'd1;
      end
   end

endmodule

>>> hdl/calendar_date_facts.sv
`timescale 1ns / 1ps
// An accepted request is held in the request register, then in the response
// register. Throughput: one transaction per cycle unless rsp_stall holds the
// pipe; the date logic is a single pass between those two registers.
// Reset (synchronous, active high) empties both stages; payload is not reset.
`include "calendar_date_facts_defines.svh"
module calendar_date_facts (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cdf_pkg::DayWidth-1:0]  req_day,
   input  logic [cdf_pkg::MonthWidth-1:0] req_month,
   input  logic [cdf_pkg::YearWidth-1:0] req_year,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_weekday,
   output logic                          rsp_is_week_end_day,
   output logic                          rsp_is_weekend,
   output logic                          rsp_is_business_day,
   output logic [2:0]                    rsp_days_to_week_end,
   output logic                          rsp_is_leap,
   output logic [4:0]                    rsp_month_length,
   output logic [4:0]                    rsp_days_to_month_end,
   output logic [8:0]                    rsp_days_to_year_end,
   output logic                          rsp_valid_res
);
   import cdf_pkg::*;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [DayWidth-1:0]   day_ff;
   logic [MonthWidth-1:0] month_ff;
   logic [YearWidth-1:0]  year_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   result_type            result_ff;
   result_type            result_in;
   logic                  s1_move;
   logic                  req_take;

   assign s1_move  = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_take = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   cdf_calc u_calc (
      .day    (day_ff),
      .month  (month_ff),
      .year   (year_ff),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         day_ff   <= req_day;
         month_ff <= req_month;
         year_ff  <= req_year;
      end
      if (s1_move) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_weekday           = result_ff.weekday;
   assign rsp_is_week_end_day   = result_ff.is_week_end_day;
   assign rsp_is_weekend        = result_ff.is_weekend;
   assign rsp_is_business_day   = result_ff.is_business_day;
   assign rsp_days_to_week_end  = result_ff.days_to_week_end;
   assign rsp_is_leap           = result_ff.is_leap;
   assign rsp_month_length      = result_ff.month_length;
   assign rsp_days_to_month_end = result_ff.days_to_month_end;
   assign rsp_days_to_year_end  = result_ff.days_to_year_end;
   assign rsp_valid_res         = result_ff.valid_res;

   `CDF_ASSERT_IMPL(a_stall_only_when_full, req_stall, s1_valid_ff && rsp_valid_ff, "stall with room")
   `CDF_ASSERT_IMPL(a_invalid_zero, rsp_valid && !rsp_valid_res, (rsp_weekday == 3'd0) && (rsp_days_to_year_end == 9'd0) && (rsp_days_to_month_end == 5'd0), "invalid date not zeroed")
   `CDF_ASSERT_IMPL(a_week_count, rsp_valid && rsp_valid_res, (rsp_weekday <= WD_SATURDAY) && (rsp_days_to_week_end == WD_SATURDAY - rsp_weekday), "weekday count mismatch")
   `CDF_ASSERT_IMPL(a_business, rsp_valid && rsp_valid_res, rsp_is_business_day != rsp_is_weekend, "business flag mismatch")
   `CDF_ASSERT_IMPL(a_month_count, rsp_valid && rsp_valid_res, (rsp_days_to_month_end != 5'd0) && (rsp_days_to_month_end <= rsp_month_length), "month count out of range")
   `CDF_ASSERT_NEXT(a_move_loads, s1_move, rsp_valid, "stage move lost")

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import cdf_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;

   localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int unsigned DAYS_AHEAD [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                               304, 334};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [DayWidth-1:0]   req_day   = '0;
   logic [MonthWidth-1:0] req_month = '0;
   logic [YearWidth-1:0]  req_year  = '0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_weekday;
   logic       rsp_is_week_end_day;
   logic       rsp_is_weekend;
   logic       rsp_is_business_day;
   logic [2:0] rsp_days_to_week_end;
   logic       rsp_is_leap;
   logic [4:0] rsp_month_length;
   logic [4:0] rsp_days_to_month_end;
   logic [8:0] rsp_days_to_year_end;
   logic       rsp_valid_res;

   result_type pending_facts [$];

   bit idle_on      = 1'b1;
   bit hold_pending = 1'b0;
   int hold_left    = 0;
   int burst_left   = 0;
   int mismatches   = 0;
   int checked      = 0;
   int sent_total   = 0;
   int sent_real    = 0;

   calendar_date_facts dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_day               (req_day),
      .req_month             (req_month),
      .req_year              (req_year),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_weekday           (rsp_weekday),
      .rsp_is_week_end_day   (rsp_is_week_end_day),
      .rsp_is_weekend        (rsp_is_weekend),
      .rsp_is_business_day   (rsp_is_business_day),
      .rsp_days_to_week_end  (rsp_days_to_week_end),
      .rsp_is_leap           (rsp_is_leap),
      .rsp_month_length      (rsp_month_length),
      .rsp_days_to_month_end (rsp_days_to_month_end),
      .rsp_days_to_year_end  (rsp_days_to_year_end),
      .rsp_valid_res         (rsp_valid_res)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   function automatic int unsigned month_len(input logic [3:0] m, input logic [13:0] y);
      if (m < MONTH_JAN || m > MONTH_DEC) return 0;
      if (m == MONTH_FEB) return leap_year(y) ? 29 : 28;
      return MONTH_LEN[m - 1];
   endfunction

   function automatic result_type date_facts(input logic [4:0] d, input logic [3:0] m,
                                             input logic [13:0] y);
      result_type  r;
      bit          leap;
      int unsigned mlen, early, shifted, march_idx, total, wd, doy;
      r = '0;
      leap = leap_year(y);
      mlen = month_len(m, y);
      r.is_leap = leap;
      r.month_length = mlen[4:0];
      if (d >= 1 && d <= mlen) begin
         // Jan and Feb count as months 11 and 12 of the year before
         early = (m <= MONTH_FEB) ? 1 : 0;
         shifted = y + 400 - early;
         march_idx = m + 12 * early - 2;
         total = d + shifted + shifted / 4 - shifted / 100 + shifted / 400
               + (31 * march_idx) / 12;
         wd = total % 7;
         doy = DAYS_AHEAD[m - 1] + d + ((leap && m > MONTH_FEB) ? 1 : 0);
         r.valid_res = 1'b1;
         r.weekday = wd[2:0];
         r.is_week_end_day = (wd == WD_SATURDAY);
         r.is_weekend = (wd == WD_FRIDAY || wd == WD_SATURDAY);
         r.is_business_day = !r.is_weekend;
         r.days_to_week_end = 3'(6 - wd);
         r.days_to_month_end = 5'(mlen - d + 1);
         r.days_to_year_end = 9'((leap ? 366 : 365) - doy + 1);
      end
      return r;
   endfunction

   function automatic string show_facts(input result_type r);
      return $sformatf({"wd=%0d sat=%0b wkend=%0b bus=%0b dtw=%0d leap=%0b ",
                        "mlen=%0d dtm=%0d dty=%0d ok=%0b"},
                       r.weekday, r.is_week_end_day, r.is_weekend, r.is_business_day,
                       r.days_to_week_end, r.is_leap, r.month_length, r.days_to_month_end,
                       r.days_to_year_end, r.valid_res);
   endfunction

   task automatic send_date(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y);
      result_type facts;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_day   <= d;
      req_month <= m;
      req_year  <= y;
      do @(posedge clock); while (req_stall);
      facts = date_facts(d, m, y);
      pending_facts.push_back(facts);
      sent_total++;
      if (facts.valid_res) sent_real++;
   endtask

   task automatic release_request();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_real_date();
      logic [13:0] y;
      logic [3:0]  m;
      int unsigned len;
      int          pick;
      pick = $urandom_range(0, 19);
      if (pick < 17) y = 14'($urandom_range(1, 9999));
      else if (pick < 18) y = 14'(100 * $urandom_range(0, 99));
      else y = 14'($urandom_range(0, 16383));
      m = 4'($urandom_range(MONTH_JAN, MONTH_DEC));
      len = month_len(m, y);
      pick = $urandom_range(0, 9);
      if (pick < 7) send_date(5'($urandom_range(1, len)), m, y);
      else if (pick < 9) send_date(5'(len), m, y);
      else send_date(1, m, y);
   endtask

   task automatic test_directed();
      send_date(1, 1, 1);
      send_date(31, 12, 9999);
      send_date(29, 2, 2000);
      send_date(29, 2, 1900);
      send_date(28, 2, 1900);
      send_date(29, 2, 2024);
      send_date(29, 2, 2023);
      send_date(1, 3, 2024);
      send_date(31, 4, 2021);
      send_date(30, 4, 2021);
      send_date(0, 5, 2020);
      send_date(31, 0, 2020);
      send_date(1, 13, 2020);
      send_date(31, 15, 16383);
      send_date(0, 0, 0);
      send_date(1, 1, 0);
      send_date(29, 2, 0);
      send_date(31, 12, 16383);
      send_date(31, 12, 2000);
      send_date(6, 1, 2023);
      send_date(7, 1, 2023);
      send_date(8, 1, 2023);
      send_date(31, 1, 1600);
      send_date(1, 3, 10000);
      release_request();
   endtask

   task automatic test_random_dates();
      for (int chunk = 0; chunk < 19; chunk++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 50; i++) send_real_date();
      end
      idle_on = 1'b1;
      release_request();
   endtask

   task automatic test_malformed();
      logic [13:0] y;
      logic [3:0]  m;
      for (int i = 0; i < 300; i++) begin
         y = 14'($urandom_range(0, 16383));
         m = 4'($urandom_range(MONTH_JAN, MONTH_DEC));
         case ($urandom_range(0, 4))
            0: send_date(5'($urandom), 4'($urandom), 14'($urandom));
            1: send_date(5'($urandom_range(month_len(m, y) + 1, 31)), m, y);
            2: send_date(5'($urandom), 4'($urandom_range(13, 15)), y);
            3: send_date(0, m, y);
            default: send_date(5'($urandom), 0, y);
         endcase
      end
      release_request();
   endtask

   // Response side holds off while requests keep coming, so the pipe fills up.
   task automatic test_output_hold();
      idle_on = 1'b0;
      while (rsp_stall) @(posedge clock);
      hold_pending = 1'b1;
      for (int i = 0; i < 80; i++) send_real_date();
      idle_on = 1'b1;
      for (int i = 0; i < 70; i++) send_real_date();
      release_request();
   endtask

   task automatic test_streaming();
      idle_on = 1'b0;
      for (int i = 0; i < 200; i++) begin
         if (i % 4 == 3) send_date(5'($urandom), 4'($urandom), 14'($urandom));
         else send_real_date();
      end
      release_request();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         burst_left = 0;
      end else begin
         if (hold_pending) begin
            hold_left = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(1, 17) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_weekday, rsp_is_week_end_day, rsp_is_weekend, rsp_is_business_day,
                 rsp_days_to_week_end, rsp_is_leap, rsp_month_length, rsp_days_to_month_end,
                 rsp_days_to_year_end, rsp_valid_res};
         if (pending_facts.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected transaction: %s", $realtime, show_facts(got));
         end else begin
            want = pending_facts.pop_front();
            checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: mismatch\n   expected %s\n   actual   %s", $realtime,
                           show_facts(want), show_facts(got));
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout with %0d transactions outstanding", pending_facts.size());
      $display("** calendar_date_facts: FAILED **");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_dates();
      test_malformed();
      test_output_hold();
      test_streaming();
      while (pending_facts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d dates (%0d real, %0d malformed), %0d responses checked",
               sent_total, sent_real, sent_total - sent_real, checked);
      $display("Years 0..16383, leap and century rules, long output hold, back-to-back tail");
      if (mismatches == 0 && pending_facts.size() == 0) begin
         $display("** calendar_date_facts: PASSED **");
      end else begin
         $display("%0d mismatches, %0d outstanding", mismatches, pending_facts.size());
         $display("** calendar_date_facts: FAILED **");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/cdf_pkg.sv
hdl/cdf_leap.sv
hdl/cdf_weekday.sv
hdl/cdf_calc.sv
hdl/calendar_date_facts.sv
test/testbench.sv
